[rtl/prfac_pkg.sv]
// Package for the prime factorizer: field widths and result limits.
// Used by prfac_div_core and prime_factorizer_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package prfac_pkg;

    localparam int VALUE_W     = 31;
    localparam int PRIME_W     = 31;
    localparam int EXP_W       = 5;
    localparam int MAX_RESULTS = 9;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int FIRST_DIV   = 2;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

`default_nettype wire

[rtl/prfac_div_core.sv]
// Restoring radix-2 divider: one quotient bit per cycle for a W-bit quotient.
// Uses prfac_pkg for the control struct; instantiated by prime_factorizer_unit.
`timescale 1ns / 1ps
`default_nettype none

module prfac_div_core #(
    parameter int W = 31
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_dividend,
    input  wire logic [W-1:0]      i_divisor,
    output prfac_pkg::t_div_ctl    o_ctl,
    output logic      [W-1:0]      o_quotient,
    output logic      [W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_den;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign shifted = {r_rem, r_quo[W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= ge ? diff[W-1:0] : shifted[W-1:0];
        end
    end

    assign o_ctl.start  = i_start;
    assign o_ctl.busy   = r_busy;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

`default_nettype wire

[rtl/prime_factorizer_unit.sv]
// Prime factorizer by trial division: sequencer around one shared divider.
// Depends on prfac_pkg and prfac_div_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_value) takes one integer item.
//   Output channel (o_out_valid / i_out_stall) returns one item per distinct
//   prime in ascending order: o_prime, o_exponent, o_last on the final one.
//   Values 0 and 1 give a single item with o_no_factors and o_last set.
//   The block takes one value at a time and stalls its input until the last
//   result of that value sits in the output register and is not stalled.
//   Each trial division passes through a start state, the divider's steps, a
//   wait for the divider to drop busy and a decision state; there is one
//   division per divisor tried and one more per power divided out. Divisors
//   run from 2 up to about sqrt(value), so a large 31-bit prime takes roughly
//   46,000 divisions. A value below 2 produces its result in the cycle after
//   acceptance.
//   When the receiver stalls, the held result stays in the output register
//   and the sequencer waits before emitting the next one.
//   Reset (synchronous, active low) returns the block to idle with no
//   pending output.
`timescale 1ns / 1ps
`default_nettype none

module prime_factorizer_unit #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [prfac_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [prfac_pkg::PRIME_W-1:0] o_prime,
    output logic      [prfac_pkg::EXP_W-1:0]   o_exponent,
    output logic                               o_no_factors,
    output logic                               o_last
);

    localparam int PW = $clog2(VALUE_BITS + 1);
    localparam int CW = prfac_pkg::COUNT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_div, n_div;
    logic [PW-1:0]         r_pow, n_pow;
    logic [CW-1:0]         r_cnt, n_cnt;

    logic                            r_ovalid, n_ovalid;
    logic [prfac_pkg::PRIME_W-1:0]   r_oprime, n_oprime;
    logic [prfac_pkg::EXP_W-1:0]     r_oexp, n_oexp;
    logic                            r_onone, n_onone;
    logic                            r_olast, n_olast;

    prfac_pkg::t_div_ctl   div_ctl;
    logic [VALUE_BITS-1:0] div_q;
    logic [VALUE_BITS-1:0] div_r;
    logic [VALUE_BITS-1:0] in_val;
    logic                  out_free;
    logic                  in_acc;
    logic                  emit_last;

    assign in_val    = VALUE_BITS'(i_value);
    assign out_free  = !r_ovalid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign emit_last = (r_rem == VALUE_BITS'(1)) ||
                       (r_cnt == CW'(prfac_pkg::MAX_RESULTS - 1));

    prfac_div_core #(
        .W (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_dividend  (r_rem),
        .i_divisor   (r_div),
        .o_ctl       (div_ctl),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_div    = r_div;
        n_pow    = r_pow;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        n_oprime = r_oprime;
        n_oexp   = r_oexp;
        n_onone  = r_onone;
        n_olast  = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_val < VALUE_BITS'(2)) begin
                        n_ovalid = 1'b1;
                        n_oprime = '0;
                        n_oexp   = '0;
                        n_onone  = 1'b1;
                        n_olast  = 1'b1;
                    end else begin
                        n_rem   = in_val;
                        n_div   = VALUE_BITS'(prfac_pkg::FIRST_DIV);
                        n_pow   = '0;
                        n_cnt   = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!div_ctl.busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // On the first division by a divisor, a quotient below the
                // divisor means divisor squared exceeds the remainder: the
                // remainder itself is the last prime.
                if ((r_pow == '0) && (r_div > div_q)) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_oprime = prfac_pkg::PRIME_W'(r_rem);
                        n_oexp   = prfac_pkg::EXP_W'(1);
                        n_onone  = 1'b0;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (div_r == '0) begin
                    n_rem   = div_q;
                    n_pow   = r_pow + PW'(1);
                    n_state = S_START;
                end else if (r_pow == '0) begin
                    n_div   = r_div + VALUE_BITS'(1);
                    n_state = S_START;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oprime = prfac_pkg::PRIME_W'(r_div);
                    n_oexp   = prfac_pkg::EXP_W'(r_pow);
                    n_onone  = 1'b0;
                    n_olast  = emit_last;
                    n_div    = r_div + VALUE_BITS'(1);
                    n_pow    = '0;
                    n_cnt    = r_cnt + CW'(1);
                    n_state  = emit_last ? S_IDLE : S_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pow    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pow    <= n_pow;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_oprime <= n_oprime;
        r_oexp   <= n_oexp;
        r_onone  <= n_onone;
        r_olast  <= n_olast;
    end

    assign o_out_valid  = r_ovalid;
    assign o_prime      = r_oprime;
    assign o_exponent   = r_oexp;
    assign o_no_factors = r_onone;
    assign o_last       = r_olast;

    // The sequencer only decides once the divider has finished.
    a_decide_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (!div_ctl.busy && !div_ctl.start))
        else $error("decision taken while divider busy");

    // A value below two yields its single flagged result on the next cycle.
    a_no_factor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_val < VALUE_BITS'(2))) |=>
        (o_out_valid && o_no_factors && o_last))
        else $error("missing no-factor result");

    // Trial divisors never drop below the first divisor during a run.
    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_div >= VALUE_BITS'(prfac_pkg::FIRST_DIV)))
        else $error("trial divisor below two");

    // A real factor always carries a nonzero power.
    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_no_factors) |-> (o_exponent != '0))
        else $error("factor emitted with zero exponent");

endmodule

`default_nettype wire
